### rtl/core/rgb_to_cielab_top_defines.svh
// Assertion macros shared by the rgb_to_cielab RTL.
// No dependencies; included by the modules that carry checks.
`ifndef RGB_TO_CIELAB_TOP_DEFINES_SVH
`define RGB_TO_CIELAB_TOP_DEFINES_SVH

// ante implies cons in the same cycle
`define RGBLAB_ASSERT_IMP(lbl, ck, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// cond must never hold
`define RGBLAB_ASSERT_NEVER(lbl, ck, rstn, cond, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rstn) !(cond)) else $error(msg);

`endif

### rtl/core/rgblab_pkg.sv
// Shared widths, constants and types for the RGB to CIELab pipeline.
// No dependencies.
package rgblab_pkg;

    // output format default
    localparam int OUT_FRAC_BITS_DEF = 8;

    // datapath widths
    localparam int COEF_W          = 16;
    localparam int ACC_W           = 26;
    localparam int NUM_W           = 34;
    localparam int T_W             = 26;
    localparam int THR_W           = 18;
    localparam int ROOT_W          = 21;
    localparam int YSQ_W           = 42;
    localparam int REM_W           = 48;
    localparam int CBRT_SHIFT      = 36;
    localparam int CBRT_N_W        = 3 * ROOT_W;
    localparam int STEPS_PER_STAGE = 3;
    localparam int CBRT_STAGES     = (ROOT_W + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
    localparam int F_FRAC          = 20;
    localparam int F_W             = 22;
    localparam int SLOPE_W         = 19;
    localparam int LLIN_W          = 26;
    localparam int LIN_L_W         = 24;
    localparam int VAL_W           = 34;
    localparam int L_W             = 15;
    localparam int AX_W            = 16;
    localparam int SCALE_DIV       = 255;

    // matrix with white point folded in, Q16, halves rounded up
    localparam logic [COEF_W-1:0] CXR = COEF_W'((64'd412453 * 64'd131072 + 64'd950456)
                                                / (64'd950456 * 64'd2));
    localparam logic [COEF_W-1:0] CXG = COEF_W'((64'd357580 * 64'd131072 + 64'd950456)
                                                / (64'd950456 * 64'd2));
    localparam logic [COEF_W-1:0] CXB = COEF_W'((64'd180423 * 64'd131072 + 64'd950456)
                                                / (64'd950456 * 64'd2));
    localparam logic [COEF_W-1:0] CYR = COEF_W'((64'd212671 * 64'd131072 + 64'd1000000)
                                                / (64'd1000000 * 64'd2));
    localparam logic [COEF_W-1:0] CYG = COEF_W'((64'd715160 * 64'd131072 + 64'd1000000)
                                                / (64'd1000000 * 64'd2));
    localparam logic [COEF_W-1:0] CYB = COEF_W'((64'd72169 * 64'd131072 + 64'd1000000)
                                                / (64'd1000000 * 64'd2));
    localparam logic [COEF_W-1:0] CZR = COEF_W'((64'd19334 * 64'd131072 + 64'd1088754)
                                                / (64'd1088754 * 64'd2));
    localparam logic [COEF_W-1:0] CZG = COEF_W'((64'd119193 * 64'd131072 + 64'd1088754)
                                                / (64'd1088754 * 64'd2));
    localparam logic [COEF_W-1:0] CZB = COEF_W'((64'd950227 * 64'd131072 + 64'd1088754)
                                                / (64'd1088754 * 64'd2));

    localparam logic [COEF_W-1:0] MATRIX [3][3] = '{
        '{CXR, CXG, CXB},
        '{CYR, CYG, CYB},
        '{CZR, CZG, CZB}
    };

    // piecewise function constants
    localparam logic [T_W-1:0] THRESH_Q24 = T_W'(((64'd8856 << 24) * 64'd2 + 64'd1000000)
                                                 / (64'd1000000 * 64'd2));
    localparam logic [SLOPE_W-1:0] SLOPE_Q16 = SLOPE_W'(((64'd7787 << 16) * 64'd2 + 64'd1000)
                                                        / (64'd1000 * 64'd2));
    localparam logic [F_W-1:0] OFFS_Q20 = F_W'(((64'd16 << 20) * 64'd2 + 64'd116)
                                               / (64'd116 * 64'd2));
    localparam logic [LLIN_W-1:0] LLIN_Q16 = LLIN_W'(((64'd9033 << 16) * 64'd2 + 64'd10)
                                                     / (64'd10 * 64'd2));

    // one normalised channel on its way through the pipe
    typedef struct packed {
        logic [T_W-1:0] t;
        logic           above;
    } chan_t;

endpackage

### rtl/core/rgblab_scale.sv
// Matrix multiply and divide-by-255 scaling: three register stages.
// Depends on rgblab_pkg and rgb_to_cielab_top_defines.svh.
`include "rgb_to_cielab_top_defines.svh"

module rgblab_scale
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [7:0]                    red,
    input  logic [7:0]                    green,
    input  logic [7:0]                    blue,
    output logic                          out_valid,
    output rgblab_pkg::chan_t [2:0]       out_chan
);

    logic [2:0]                          valid_reg;
    logic [rgblab_pkg::ACC_W-1:0]        acc_reg  [3];
    logic [rgblab_pkg::ACC_W-1:0]        acc_next [3];
    logic [rgblab_pkg::NUM_W-1:0]        num_reg  [3];
    logic [rgblab_pkg::NUM_W-1:0]        num_next [3];
    logic [rgblab_pkg::T_W-1:0]          q_reg    [3];
    logic [rgblab_pkg::T_W-1:0]          q_next   [3];
    logic [9:0]                          rem      [3];
    rgblab_pkg::chan_t [2:0]             chan_reg;
    rgblab_pkg::chan_t [2:0]             chan_next;

    // stage 1: weighted sums
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            acc_next[c] = rgblab_pkg::ACC_W'(red)   * rgblab_pkg::ACC_W'(rgblab_pkg::MATRIX[c][0])
                        + rgblab_pkg::ACC_W'(green) * rgblab_pkg::ACC_W'(rgblab_pkg::MATRIX[c][1])
                        + rgblab_pkg::ACC_W'(blue)  * rgblab_pkg::ACC_W'(rgblab_pkg::MATRIX[c][2]);
        end
    end

    // stage 2: quotient estimate by series of shifts, never above the true value
    always_comb
    begin
        logic [rgblab_pkg::NUM_W:0] ser;
        ser = '0;
        for (int c = 0; c < 3; c++)
        begin
            num_next[c] = {acc_reg[c], 8'd0} + rgblab_pkg::NUM_W'(rgblab_pkg::SCALE_DIV / 2);
            ser = (rgblab_pkg::NUM_W+1)'(num_next[c])
                + (rgblab_pkg::NUM_W+1)'(num_next[c] >> 8)
                + (rgblab_pkg::NUM_W+1)'(num_next[c] >> 16)
                + (rgblab_pkg::NUM_W+1)'(num_next[c] >> 24)
                + (rgblab_pkg::NUM_W+1)'(num_next[c] >> 32);
            q_next[c] = rgblab_pkg::T_W'(ser >> 8);
        end
    end

    // stage 3: one correction step, then threshold compare
    always_comb
    begin
        logic [rgblab_pkg::NUM_W-1:0] diff;
        logic [rgblab_pkg::T_W-1:0]   t;
        diff = '0;
        t    = '0;
        for (int c = 0; c < 3; c++)
        begin
            diff   = num_reg[c] - rgblab_pkg::NUM_W'({q_reg[c], 8'd0})
                   + rgblab_pkg::NUM_W'(q_reg[c]);
            rem[c] = diff[9:0];
            t      = q_reg[c] + rgblab_pkg::T_W'(rem[c] >= 10'(rgblab_pkg::SCALE_DIV));
            chan_next[c].t     = t;
            chan_next[c].above = t > rgblab_pkg::THRESH_Q24;
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[1:0], in_valid};
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            acc_reg  <= acc_next;
            num_reg  <= num_next;
            q_reg    <= q_next;
            chan_reg <= chan_next;
        end
    end

    assign out_valid = valid_reg[2];
    assign out_chan  = chan_reg;

    `RGBLAB_ASSERT_IMP(a_div_corr, clk, rst_n, valid_reg[1], (rem[0] < 10'd510) && (rem[1] < 10'd510) && (rem[2] < 10'd510), "divide estimate off by more than one")

endmodule

### rtl/core/rgblab_cbrt.sv
// Pipelined digit-by-digit integer cube root, three lanes side by side.
// Depends on rgblab_pkg and rgb_to_cielab_top_defines.svh.
`include "rgb_to_cielab_top_defines.svh"

module rgblab_cbrt
(
    input  logic                                           clk,
    input  logic                                           rst_n,
    input  logic                                           en,
    input  logic                                           in_valid,
    input  rgblab_pkg::chan_t [2:0]                        in_chan,
    output logic                                           out_valid,
    output rgblab_pkg::chan_t [2:0]                        out_chan,
    output logic [2:0][rgblab_pkg::ROOT_W-1:0]             out_root
);

    typedef struct packed {
        rgblab_pkg::chan_t                ch;
        logic [rgblab_pkg::ROOT_W-1:0]    root;
        logic [rgblab_pkg::YSQ_W-1:0]     ysq;
        logic [rgblab_pkg::REM_W-1:0]     rem;
    } lane_t;

    localparam int NS = rgblab_pkg::CBRT_STAGES;

    // one result bit: bring in three radicand bits, try root*2+1
    function automatic lane_t cbrt_step(input lane_t li, input int g);
        logic [rgblab_pkg::CBRT_N_W-1:0] n;
        logic [2:0]                      grp;
        logic [rgblab_pkg::ROOT_W-1:0]   y2;
        logic [rgblab_pkg::YSQ_W-1:0]    ysq2;
        logic [rgblab_pkg::REM_W-1:0]    rem_s;
        logic [rgblab_pkg::REM_W-1:0]    sum;
        logic [rgblab_pkg::REM_W-1:0]    bnd;
        lane_t                           lo;
        n     = rgblab_pkg::CBRT_N_W'({li.ch.t, {rgblab_pkg::CBRT_SHIFT{1'b0}}});
        grp   = 3'(n >> (3 * g));
        y2    = {li.root[rgblab_pkg::ROOT_W-2:0], 1'b0};
        ysq2  = {li.ysq[rgblab_pkg::YSQ_W-3:0], 2'b00};
        rem_s = {li.rem[rgblab_pkg::REM_W-4:0], grp};
        sum   = rgblab_pkg::REM_W'(ysq2) + rgblab_pkg::REM_W'(y2);
        bnd   = (sum << 1) + sum + rgblab_pkg::REM_W'(1);
        lo    = li;
        if (rem_s >= bnd)
        begin
            lo.rem  = rem_s - bnd;
            lo.root = y2 | rgblab_pkg::ROOT_W'(1);
            lo.ysq  = ysq2 + rgblab_pkg::YSQ_W'({y2, 1'b0}) + rgblab_pkg::YSQ_W'(1);
        end
        else
        begin
            lo.rem  = rem_s;
            lo.root = y2;
            lo.ysq  = ysq2;
        end
        return lo;
    endfunction

    logic [NS-1:0]  valid_reg;
    lane_t [2:0]    stg_reg  [NS];
    lane_t [2:0]    stg_next [NS];
    lane_t          last_y;
    logic [rgblab_pkg::REM_W-1:0] last_bnd;

    // each stage resolves STEPS_PER_STAGE result bits per lane
    always_comb
    begin
        lane_t cur;
        int    g;
        cur = '0;
        g   = 0;
        for (int s = 0; s < NS; s++)
        begin
            for (int l = 0; l < 3; l++)
            begin
                if (s == 0)
                begin
                    cur    = '0;
                    cur.ch = in_chan[l];
                end
                else
                begin
                    cur = stg_reg[s-1][l];
                end
                for (int j = 0; j < rgblab_pkg::STEPS_PER_STAGE; j++)
                begin
                    g = rgblab_pkg::ROOT_W - 1 - (s * rgblab_pkg::STEPS_PER_STAGE + j);
                    if (g >= 0)
                    begin
                        cur = cbrt_step(cur, g);
                    end
                end
                stg_next[s][l] = cur;
            end
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= NS'({valid_reg, in_valid});
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            stg_reg <= stg_next;
        end
    end

    // outputs
    always_comb
    begin
        for (int l = 0; l < 3; l++)
        begin
            out_chan[l] = stg_reg[NS-1][l].ch;
            out_root[l] = stg_reg[NS-1][l].root;
        end
    end

    assign out_valid = valid_reg[NS-1];

    // remainder left over must be below the next cube step
    assign last_y   = stg_reg[NS-1][1];
    assign last_bnd = (rgblab_pkg::REM_W'(last_y.ysq) + rgblab_pkg::REM_W'(last_y.root)) * 3
                    + rgblab_pkg::REM_W'(1);

    `RGBLAB_ASSERT_IMP(a_cbrt_rem, clk, rst_n, valid_reg[NS-1], last_y.rem < last_bnd, "cube root remainder out of range")

endmodule

### rtl/core/rgblab_finish.sv
// Branch select, L/a/b forming, rounding and saturation: three stages.
// Depends on rgblab_pkg and rgb_to_cielab_top_defines.svh.
`include "rgb_to_cielab_top_defines.svh"

module rgblab_finish
#(
    parameter int OUT_FRAC_BITS = rgblab_pkg::OUT_FRAC_BITS_DEF
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   en,
    input  logic                                   in_valid,
    input  rgblab_pkg::chan_t [2:0]                in_chan,
    input  logic [2:0][rgblab_pkg::ROOT_W-1:0]     in_root,
    output logic                                   out_valid,
    output logic [rgblab_pkg::L_W-1:0]             lightness,
    output logic signed [rgblab_pkg::AX_W-1:0]     green_red_axis,
    output logic signed [rgblab_pkg::AX_W-1:0]     blue_yellow_axis
);

    localparam int VW      = rgblab_pkg::VAL_W;
    localparam int RSH     = rgblab_pkg::F_FRAC - OUT_FRAC_BITS;
    localparam int LMAX_I  = ((100 << OUT_FRAC_BITS) > 32767) ? 32767 : (100 << OUT_FRAC_BITS);
    localparam logic signed [VW-1:0] HALF   = VW'(1) << (RSH - 1);
    localparam logic signed [VW-1:0] LMAX   = VW'(LMAX_I);
    localparam logic signed [VW-1:0] AX_MAX = VW'(32767);
    localparam logic signed [VW-1:0] AX_MIN = -VW'(32768);
    localparam logic signed [VW-1:0] K_L    = VW'(116);
    localparam logic signed [VW-1:0] K_A    = VW'(500);
    localparam logic signed [VW-1:0] K_B    = VW'(200);
    localparam logic signed [VW-1:0] L_OFFS = VW'(16) << rgblab_pkg::F_FRAC;
    localparam int PS_W = rgblab_pkg::SLOPE_W + rgblab_pkg::THR_W;
    localparam int PL_W = rgblab_pkg::LLIN_W + rgblab_pkg::THR_W;

    function automatic logic signed [VW-1:0] round_out(input logic signed [VW-1:0] v);
        logic [VW-1:0] mag;
        mag = v[VW-1] ? VW'(-v) : VW'(v);
        mag = (mag + VW'(HALF)) >> RSH;
        return v[VW-1] ? -$signed(mag) : $signed(mag);
    endfunction

    function automatic logic signed [VW-1:0] clamp(input logic signed [VW-1:0] v,
                                                   input logic signed [VW-1:0] lo,
                                                   input logic signed [VW-1:0] hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    logic [2:0]                               valid_reg;
    logic [rgblab_pkg::F_W-1:0]               f_reg    [3];
    logic [rgblab_pkg::F_W-1:0]               f_next   [3];
    logic [rgblab_pkg::LIN_L_W-1:0]           llin_reg;
    logic [rgblab_pkg::LIN_L_W-1:0]           llin_next;
    logic                                     ya_reg;
    logic signed [VW-1:0]                     l20_reg, a20_reg, b20_reg;
    logic signed [VW-1:0]                     l20_next, a20_next, b20_next;
    logic [rgblab_pkg::L_W-1:0]               l_reg, l_next;
    logic signed [rgblab_pkg::AX_W-1:0]       a_reg, a_next, b_reg, b_next;

    // stage 1: pick cube root or linear segment; linear lightness
    always_comb
    begin
        logic [PS_W-1:0] ps;
        logic [PL_W-1:0] pl;
        ps = '0;
        for (int c = 0; c < 3; c++)
        begin
            ps = PS_W'(rgblab_pkg::SLOPE_Q16) * PS_W'(in_chan[c].t[rgblab_pkg::THR_W-1:0]);
            if (in_chan[c].above)
            begin
                f_next[c] = rgblab_pkg::F_W'(in_root[c]);
            end
            else
            begin
                f_next[c] = rgblab_pkg::F_W'((ps + (PS_W'(1) << (rgblab_pkg::F_FRAC - 1)))
                                             >> rgblab_pkg::F_FRAC) + rgblab_pkg::OFFS_Q20;
            end
        end
        pl = PL_W'(rgblab_pkg::LLIN_Q16) * PL_W'(in_chan[1].t[rgblab_pkg::THR_W-1:0]);
        llin_next = rgblab_pkg::LIN_L_W'((pl + (PL_W'(1) << (rgblab_pkg::F_FRAC - 1)))
                                         >> rgblab_pkg::F_FRAC);
    end

    // stage 2: L, a, b at 20 fraction bits
    always_comb
    begin
        logic signed [VW-1:0] fx, fy, fz;
        fx = VW'(f_reg[0]);
        fy = VW'(f_reg[1]);
        fz = VW'(f_reg[2]);
        l20_next = ya_reg ? (fy * K_L - L_OFFS) : VW'(llin_reg);
        a20_next = (fx - fy) * K_A;
        b20_next = (fy - fz) * K_B;
    end

    // stage 3: round half away from zero, saturate
    always_comb
    begin
        l_next = rgblab_pkg::L_W'(clamp(round_out(l20_reg), '0, LMAX));
        a_next = rgblab_pkg::AX_W'(clamp(round_out(a20_reg), AX_MIN, AX_MAX));
        b_next = rgblab_pkg::AX_W'(clamp(round_out(b20_reg), AX_MIN, AX_MAX));
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[1:0], in_valid};
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f_reg    <= f_next;
            llin_reg <= llin_next;
            ya_reg   <= in_chan[1].above;
            l20_reg  <= l20_next;
            a20_reg  <= a20_next;
            b20_reg  <= b20_next;
            l_reg    <= l_next;
            a_reg    <= a_next;
            b_reg    <= b_next;
        end
    end

    assign out_valid        = valid_reg[2];
    assign lightness        = l_reg;
    assign green_red_axis   = a_reg;
    assign blue_yellow_axis = b_reg;

    `RGBLAB_ASSERT_NEVER(a_l_limit, clk, rst_n, valid_reg[2] && (VW'(l_reg) > LMAX), "lightness above its limit")

endmodule

### rtl/core/rgb_to_cielab_top.sv
// RGB to CIELab (D65) converter, top level.
// Depends on rgblab_pkg, rgblab_scale, rgblab_cbrt, rgblab_finish.
//
// Usage:
//   Input channel s_*: one pixel per item, s_tdata = {blue, green, red}.
//   Output channel m_*: one result item per pixel, in order, L* unsigned and
//   a*, b* signed, all with OUT_FRAC_BITS fraction bits, saturated.
//   Depth: 13 register stages (3 scaling, 7 cube-root, 3 forming/rounding);
//   m_tvalid rises once an accepted item has passed through all of them.
//   Throughput: one item per cycle unless m_tready stalls; the cube root
//   resolves three result bits per stage, so its 21 bits set the pipeline depth.
//   Flow control: the whole pipe advances whenever the output register is
//   empty or being taken; s_tready is high in exactly those cycles, so a
//   stall on m_tready holds every stage and nothing is lost or repeated.
//   Reset: rst_n clears all valid bits; the pipe is empty and accepting
//   right after reset.

module rgb_to_cielab_top
#(
    parameter int OUT_FRAC_BITS = rgblab_pkg::OUT_FRAC_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // red[7:0], green[15:8], blue[23:16]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // lightness[14:0], green_red_axis[30:15],
                                   // blue_yellow_axis[46:31], zero[47]
);

    logic                                   en;
    logic                                   sc_valid;
    rgblab_pkg::chan_t [2:0]                sc_chan;
    logic                                   cb_valid;
    rgblab_pkg::chan_t [2:0]                cb_chan;
    logic [2:0][rgblab_pkg::ROOT_W-1:0]     cb_root;
    logic [rgblab_pkg::L_W-1:0]             lightness;
    logic signed [rgblab_pkg::AX_W-1:0]     green_red_axis;
    logic signed [rgblab_pkg::AX_W-1:0]     blue_yellow_axis;

    // global advance
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    rgblab_scale u_scale
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_tvalid),
        .red       (s_tdata[7:0]),
        .green     (s_tdata[15:8]),
        .blue      (s_tdata[23:16]),
        .out_valid (sc_valid),
        .out_chan  (sc_chan)
    );

    rgblab_cbrt u_cbrt
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sc_valid),
        .in_chan   (sc_chan),
        .out_valid (cb_valid),
        .out_chan  (cb_chan),
        .out_root  (cb_root)
    );

    rgblab_finish #(
        .OUT_FRAC_BITS (OUT_FRAC_BITS)
    ) u_finish
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .en               (en),
        .in_valid         (cb_valid),
        .in_chan          (cb_chan),
        .in_root          (cb_root),
        .out_valid        (m_tvalid),
        .lightness        (lightness),
        .green_red_axis   (green_red_axis),
        .blue_yellow_axis (blue_yellow_axis)
    );

    assign m_tdata = {1'b0, blue_yellow_axis, green_red_axis, lightness};

endmodule

### sim/tb.sv
// Testbench for rgb_to_cielab_top: random and directed pixels, checked against
// a fixed-point CIELab predictor held in a small scoreboard class.
// Depends on rgblab_pkg and the rgb_to_cielab_top RTL.
module tb;

    localparam int FRAC     = rgblab_pkg::OUT_FRAC_BITS_DEF;
    localparam int N_RANDOM = 800;

    // colour conversion result, one per pixel
    typedef struct packed {
        logic [14:0] lightness;
        logic [15:0] green_red_axis;
        logic [15:0] blue_yellow_axis;
    } lab_t;

    class lab_scoreboard;
        lab_t pending_lab[$];
        int   mismatches;
        int   checked;

        function longint unsigned norm_q24(longint unsigned r, longint unsigned g,
                                           longint unsigned b, int row);
            longint unsigned acc;
            acc = r * rgblab_pkg::MATRIX[row][0] + g * rgblab_pkg::MATRIX[row][1]
                + b * rgblab_pkg::MATRIX[row][2];
            return (acc * 256 + 127) / 255;
        endfunction

        function longint cube_root_q20(longint unsigned n);
            longint unsigned root;
            longint unsigned trial;
            root = 0;
            for (int bitpos = 20; bitpos >= 0; bitpos--)
            begin
                trial = root | (64'd1 << bitpos);
                if (trial * trial * trial <= n)
                    root = trial;
            end
            return longint'(root);
        endfunction

        function longint lab_curve(longint unsigned t);
            if (t > rgblab_pkg::THRESH_Q24)
                return cube_root_q20(t << 36);
            return longint'(((64'(rgblab_pkg::SLOPE_Q16) * t + (64'd1 << 19)) >> 20)
                            + rgblab_pkg::OFFS_Q20);
        endfunction

        function longint to_out_frac(longint v);
            longint unsigned half;
            half = 64'd1 << (19 - FRAC);
            if (v >= 0)
                return longint'((unsigned'(v) + half) >> (20 - FRAC));
            return -longint'((unsigned'(-v) + half) >> (20 - FRAC));
        endfunction

        function longint sat(longint v, longint lo, longint hi);
            return v < lo ? lo : (v > hi ? hi : v);
        endfunction

        function void note_pixel(logic [7:0] red, logic [7:0] green, logic [7:0] blue);
            longint unsigned xq, yq, zq;
            longint fx, fy, fz, l20, lmax;
            lab_t res;
            xq = norm_q24(red, green, blue, 0);
            yq = norm_q24(red, green, blue, 1);
            zq = norm_q24(red, green, blue, 2);
            fx = lab_curve(xq);
            fy = lab_curve(yq);
            fz = lab_curve(zq);
            if (yq > rgblab_pkg::THRESH_Q24)
                l20 = 116 * fy - (longint'(16) << 20);
            else
                l20 = longint'((64'(rgblab_pkg::LLIN_Q16) * yq + (64'd1 << 19)) >> 20);
            lmax = longint'(100) << FRAC;
            if (lmax > 32767)
                lmax = 32767;
            res.lightness        = 15'(sat(to_out_frac(l20), 0, lmax));
            res.green_red_axis   = 16'(sat(to_out_frac(500 * (fx - fy)), -32768, 32767));
            res.blue_yellow_axis = 16'(sat(to_out_frac(200 * (fy - fz)), -32768, 32767));
            pending_lab.push_back(res);
        endfunction

        function void check_lab(logic [47:0] data);
            lab_t want;
            lab_t got;
            got = {data[30:15], data[46:31], data[14:0]};
            got.lightness        = data[14:0];
            got.green_red_axis   = data[30:15];
            got.blue_yellow_axis = data[46:31];
            if (pending_lab.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, data);
                mismatches++;
                return;
            end
            want = pending_lab.pop_front();
            checked++;
            if (got.lightness !== want.lightness)
            begin
                $display("%0t: L expected %0d actual %0d", $time, want.lightness,
                         got.lightness);
                mismatches++;
            end
            if (got.green_red_axis !== want.green_red_axis)
            begin
                $display("%0t: a expected %0d actual %0d", $time,
                         $signed(want.green_red_axis), $signed(got.green_red_axis));
                mismatches++;
            end
            if (got.blue_yellow_axis !== want.blue_yellow_axis)
            begin
                $display("%0t: b expected %0d actual %0d", $time,
                         $signed(want.blue_yellow_axis), $signed(got.blue_yellow_axis));
                mismatches++;
            end
            if (data[47] !== 1'b0)
            begin
                $display("%0t: pad bit expected 0 actual %b", $time, data[47]);
                mismatches++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;

    lab_scoreboard lab_sb;
    int            burst_left;
    int            stall_mode;
    int            pixels_sent;

    rgb_to_cielab_top u_top
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // red[7:0], green[15:8], blue[23:16]
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)    // lightness, green_red_axis, blue_yellow_axis
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // sample the output handshake at the rising edge
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            lab_sb.check_lab(m_tdata);
    end

    // receiver stall pattern: phases of always ready, random, and mostly stalled
    always @(negedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if ($urandom_range(0, 199) == 0)
                stall_mode = $urandom_range(0, 2);
            case (stall_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= ($urandom_range(0, 1) == 1);
                default: m_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // offer one pixel, with sender gaps between bursts
    task automatic send_pixel(input logic [7:0] red, input logic [7:0] green,
                              input logic [7:0] blue);
        if (burst_left == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {blue, green, red};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        lab_sb.note_pixel(red, green, blue);
        pixels_sent++;
        @(negedge clk);
    endtask

    initial
    begin
        lab_sb     = new();
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        m_tready   = 1'b0;
        burst_left = 0;
        stall_mode = 0;
        pixels_sent = 0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        // extremes, primaries, near-threshold darks and single-bit patterns
        send_pixel(8'd0,   8'd0,   8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd255, 8'd0,   8'd0);
        send_pixel(8'd0,   8'd255, 8'd0);
        send_pixel(8'd0,   8'd0,   8'd255);
        send_pixel(8'd255, 8'd255, 8'd0);
        send_pixel(8'd255, 8'd0,   8'd255);
        send_pixel(8'd0,   8'd255, 8'd255);
        send_pixel(8'd1,   8'd1,   8'd1);
        send_pixel(8'd2,   8'd2,   8'd2);
        send_pixel(8'd3,   8'd3,   8'd3);
        send_pixel(8'd0,   8'd3,   8'd0);
        send_pixel(8'd7,   8'd0,   8'd0);
        send_pixel(8'd0,   8'd0,   8'd9);
        send_pixel(8'd170, 8'd85,  8'd170);
        send_pixel(8'd85,  8'd170, 8'd85);
        send_pixel(8'd128, 8'd128, 8'd128);
        send_pixel(8'd0,   8'd1,   8'd255);
        send_pixel(8'd255, 8'd1,   8'd0);

        // random pixels: mostly full range, some dark near the linear branch
        repeat (N_RANDOM)
        begin
            if ($urandom_range(0, 3) == 0)
                send_pixel(8'($urandom_range(0, 12)), 8'($urandom_range(0, 12)),
                           8'($urandom_range(0, 12)));
            else
                send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
        end
        s_tvalid <= 1'b0;

        while (lab_sb.pending_lab.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);

        $display("covered %0d pixels: colour extremes, dark linear-branch values, random",
                 pixels_sent);
        $display("%0d results checked, %0d mismatches", lab_sb.checked,
                 lab_sb.mismatches);
        if (lab_sb.mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // run limit
    initial
    begin
        #400000;
        $display("timeout");
        $display("status: fail");
        $finish;
    end

endmodule

### rgb_to_cielab_top.f
+incdir+rtl/core
rtl/core/rgblab_pkg.sv
rtl/core/rgblab_scale.sv
rtl/core/rgblab_cbrt.sv
rtl/core/rgblab_finish.sv
rtl/core/rgb_to_cielab_top.sv
sim/tb.sv
